### hw/rtl/ray_disk_cap_intersect_macros.svh
// Assertion macros shared by the ray/disk cap checker.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef RAY_DISK_CAP_INTERSECT_MACROS_SVH
`define RAY_DISK_CAP_INTERSECT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RDC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/rdc_pkg.sv
// Shared constants, register codes and helpers for the ray/disk cap intersector.
// No dependencies; imported by the top level, the checker and the testbench.
`default_nettype none
package rdc_pkg;

	localparam int FRAC_BITS          = 16;
	localparam int MIN_T_LSB          = 1;
	localparam int PARALLEL_LIMIT_LSB = 1;

	localparam int VAL_W   = 32;
	localparam int T_W     = 31;
	localparam int IB_W    = T_W - FRAC_BITS;   // integer bits of the quotient
	localparam int TD_W    = 64 - FRAC_BITS;    // scaled dir*axis term
	localparam int TN_W    = 65 - FRAC_BITS;    // scaled (center-origin)*axis term
	localparam int NUM_W   = 67 - FRAC_BITS;    // sums of three terms
	localparam int MAG_W   = NUM_W;
	localparam int PT_W    = 65 - FRAC_BITS;    // wide hit point
	localparam int DF_W    = 66 - FRAC_BITS;    // point minus center
	localparam int SQ_W    = 64 - FRAC_BITS;    // scaled square
	localparam int DIST_W  = 66 - FRAC_BITS;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int IN_TDATA_W  = 224;
	localparam int OUT_TDATA_W = 256;

	// Result packing, lowest bit first.
	localparam int O_HIT   = 0;
	localparam int O_T     = 1;
	localparam int O_PT    = 32;
	localparam int O_NRM   = 128;
	localparam int O_NEAR  = 224;

	localparam logic [VAL_W-1:0] AXIS_Y_RESET = 32'h0001_0000;
	localparam logic [T_W-1:0]   RSQ_RESET    = 31'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CTR_X, REG_CTR_Y, REG_CTR_Z,
		REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z,
		REG_RSQ, REG_NSIGN
	} cfg_reg_t;

	function automatic logic [VAL_W-1:0] sat32(input logic signed [PT_W-1:0] v);
		logic signed [PT_W-1:0] hi;
		logic signed [PT_W-1:0] lo;
		hi = PT_W'(33'sh0_7FFF_FFFF);
		lo = PT_W'(-33'sh0_8000_0000);
		if (v > hi) begin
			return 32'h7FFF_FFFF;
		end else if (v < lo) begin
			return 32'h8000_0000;
		end
		return v[VAL_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ray_disk_cap_intersect.sv
// Pipelined ray versus circular cap test, one ray per cycle if unstalled.
// Depends on rdc_pkg for constants, register codes and saturation.
//
// Usage:
//  - Configuration: cfg_we/cfg_index/cfg_data write one cap register per
//    cycle (center x/y/z, axis x/y/z, squared radius, normal sign). Write
//    only while no transaction is in flight.
//  - Input stream s_axis_*: one ray per transaction (origin, direction,
//    nearest distance so far).
//  - Output stream m_axis_*: exactly one result per ray, in order.
//  - From input transaction to output valid a ray passes through three
//    stages for products, sums and sign checks, 31 restoring-division
//    stages (one quotient bit each) for t, then four stages for the
//    point products, point and range check, squares and radius compare.
//  - One ray per cycle unless stalled; the division chain sets the depth.
//  - All stages advance together. When m_axis_tready is low and a result
//    is waiting, the whole pipeline holds and s_axis_tready drops; nothing
//    is lost or repeated. Bubbles move forward while the output is empty.
//  - Reset clears all valid bits and loads the register reset values
//    (axis along +y, squared radius 1.0, bottom-cap normal).
`default_nettype none
module ray_disk_cap_intersect (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_t, pad
	input  logic [rdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// hit_found, hit_t, point_x/y/z, normal_x/y/z, new_nearest_t, pad
	output logic [rdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import rdc_pkg::*;

	localparam int DIV_N = T_W;

	// Members from the highest bits down: nearest, direction, origin.
	typedef struct packed {
		logic [T_W-1:0]        near;
		logic [2:0][VAL_W-1:0] dir;
		logic [2:0][VAL_W-1:0] org;
	} ray_t;

	// Cap registers
	logic signed [VAL_W-1:0] ctr_q  [3];
	logic signed [VAL_W-1:0] axis_q [3];
	logic [T_W-1:0]          rsq_q;
	logic                    nsign_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q[0]  <= '0;
			ctr_q[1]  <= '0;
			ctr_q[2]  <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= AXIS_Y_RESET;
			axis_q[2] <= '0;
			rsq_q     <= RSQ_RESET;
			nsign_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CTR_X:  ctr_q[0]  <= cfg_data;
				REG_CTR_Y:  ctr_q[1]  <= cfg_data;
				REG_CTR_Z:  ctr_q[2]  <= cfg_data;
				REG_AXIS_X: axis_q[0] <= cfg_data;
				REG_AXIS_Y: axis_q[1] <= cfg_data;
				REG_AXIS_Z: axis_q[2] <= cfg_data;
				REG_RSQ:    rsq_q     <= cfg_data[T_W-1:0];
				REG_NSIGN:  nsign_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Global advance: the output register is free or being drained.
	logic en;
	logic v_s7;
	assign en            = !v_s7 || m_axis_tready;
	assign s_axis_tready = en;

	ray_t ray_in;
	assign ray_in = ray_t'(s_axis_tdata[IN_TDATA_W-2:0]);

	// Stage 1: the six plane products, scaled by floor.
	logic signed [63:0] pd [3];
	logic signed [32:0] dc [3];
	logic signed [64:0] pn [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pd[i] = $signed(ray_in.dir[i]) * axis_q[i];
			dc[i] = 33'(ctr_q[i]) - 33'($signed(ray_in.org[i]));
			pn[i] = 65'(dc[i]) * 65'(axis_q[i]);
		end
	end

	logic                   v_s1;
	ray_t                   ray_s1;
	logic signed [TD_W-1:0] den_t_s1 [3];
	logic signed [TN_W-1:0] num_t_s1 [3];

	// Stage 2: sums
	logic                    v_s2;
	ray_t                    ray_s2;
	logic signed [NUM_W-1:0] den_s2, num_s2;

	// Stage 3: magnitudes, early misses, division seed
	logic [MAG_W-1:0] nd_c, nn_c;
	always_comb begin
		nd_c = den_s2[NUM_W-1] ? MAG_W'(-den_s2) : MAG_W'(den_s2);
		nn_c = num_s2[NUM_W-1] ? MAG_W'(-num_s2) : MAG_W'(num_s2);
	end

	logic             v_s3;
	ray_t             ray_s3;
	logic [MAG_W-1:0] rem_s3, nd_s3;
	logic [IB_W-1:0]  nlow_s3;
	logic             miss_s3;

	// Division chain, index 0 is the stage 3 output
	logic             dv_v    [DIV_N+1];
	ray_t             dv_ray  [DIV_N+1];
	logic [MAG_W-1:0] dv_rem  [DIV_N+1];
	logic [MAG_W-1:0] dv_nd   [DIV_N+1];
	logic [IB_W-1:0]  dv_nlow [DIV_N+1];
	logic [T_W-1:0]   dv_q    [DIV_N+1];
	logic             dv_miss [DIV_N+1];

	assign dv_v[0]    = v_s3;
	assign dv_ray[0]  = ray_s3;
	assign dv_rem[0]  = rem_s3;
	assign dv_nd[0]   = nd_s3;
	assign dv_nlow[0] = nlow_s3;
	assign dv_q[0]    = '0;
	assign dv_miss[0] = miss_s3;

	for (genvar j = 0; j < DIV_N; j++) begin : g_div
		localparam int K = T_W - 1 - j;
		logic             bin;
		logic [MAG_W:0]   trial;
		logic [MAG_W:0]   diff;
		logic             ge;
		if (K >= FRAC_BITS) begin : g_int
			assign bin = dv_nlow[j][K-FRAC_BITS];
		end else begin : g_frac
			assign bin = 1'b0;
		end
		assign trial = {dv_rem[j], bin};
		assign diff  = trial - {1'b0, dv_nd[j]};
		assign ge    = trial >= {1'b0, dv_nd[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ray[j+1]  <= dv_ray[j];
				dv_nd[j+1]   <= dv_nd[j];
				dv_nlow[j+1] <= dv_nlow[j];
				dv_miss[j+1] <= dv_miss[j];
				dv_rem[j+1]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
				dv_q[j+1]    <= {dv_q[j][T_W-2:0], ge};
			end
		end
	end

	// Stage 4: range check on t, direction times t
	logic [T_W-1:0]     t_c;
	logic               tok_c;
	logic signed [63:0] pp [3];
	always_comb begin
		t_c   = dv_q[DIV_N];
		tok_c = !dv_miss[DIV_N] && (t_c > T_W'(MIN_T_LSB)) && (t_c < dv_ray[DIV_N].near);
		for (int i = 0; i < 3; i++) begin
			pp[i] = $signed(dv_ray[DIV_N].dir[i]) * $signed({1'b0, t_c});
		end
	end

	logic                   v_s4;
	ray_t                   ray_s4;
	logic [T_W-1:0]         t_s4;
	logic                   cand_s4;
	logic signed [TD_W-1:0] pp_s4 [3];

	// Stage 5: point, offset from center, far check
	logic signed [PT_W-1:0] pt_c [3];
	logic signed [DF_W-1:0] df_c [3];
	logic [DF_W-1:0]        mg_c [3];
	logic                   far_c;
	always_comb begin
		far_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pt_c[i] = PT_W'($signed(ray_s4.org[i])) + PT_W'(pp_s4[i]);
			df_c[i] = DF_W'(pt_c[i]) - DF_W'(ctr_q[i]);
			mg_c[i] = df_c[i][DF_W-1] ? DF_W'(-df_c[i]) : DF_W'(df_c[i]);
			if (mg_c[i][DF_W-1:VAL_W] != '0) begin
				far_c = 1'b1;
			end
		end
	end

	logic             v_s5;
	logic [T_W-1:0]   t_s5, near_s5;
	logic             cand_s5;
	logic [VAL_W-1:0] pt_s5 [3];
	logic [VAL_W-1:0] mg_s5 [3];

	// Stage 6: scaled squares
	logic [63:0] sqf [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqf[i] = 64'(mg_s5[i]) * 64'(mg_s5[i]);
		end
	end

	logic             v_s6;
	logic [T_W-1:0]   t_s6, near_s6;
	logic             cand_s6;
	logic [VAL_W-1:0] pt_s6 [3];
	logic [SQ_W-1:0]  sq_s6 [3];

	// Stage 7: radius compare and result assembly
	logic [DIST_W-1:0]      dist_c;
	logic                   hit_c;
	logic [VAL_W-1:0]       nrm_c [3];
	logic [OUT_TDATA_W-1:0] out_c;
	always_comb begin
		dist_c = DIST_W'(sq_s6[0]) + DIST_W'(sq_s6[1]) + DIST_W'(sq_s6[2]);
		hit_c  = cand_s6 && (dist_c <= DIST_W'(rsq_q));
		for (int i = 0; i < 3; i++) begin
			if (nsign_q) begin
				nrm_c[i] = axis_q[i];
			end else if (axis_q[i] == 32'sh8000_0000) begin
				nrm_c[i] = 32'h7FFF_FFFF;
			end else begin
				nrm_c[i] = -axis_q[i];
			end
		end
		// a miss zeroes every field but the carried nearest distance
		out_c = '0;
		if (hit_c) begin
			out_c[O_HIT]         = 1'b1;
			out_c[O_T +: T_W]    = t_s6;
			out_c[O_NEAR +: T_W] = t_s6;
			for (int i = 0; i < 3; i++) begin
				out_c[O_PT + VAL_W*i +: VAL_W]  = pt_s6[i];
				out_c[O_NRM + VAL_W*i +: VAL_W] = nrm_c[i];
			end
		end else begin
			out_c[O_NEAR +: T_W] = near_s6;
		end
	end

	logic [OUT_TDATA_W-1:0] out_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= dv_v[DIV_N];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray_in;
			for (int i = 0; i < 3; i++) begin
				den_t_s1[i] <= pd[i][63:FRAC_BITS];
				num_t_s1[i] <= pn[i][64:FRAC_BITS];
			end

			ray_s2 <= ray_s1;
			den_s2 <= NUM_W'(den_t_s1[0]) + NUM_W'(den_t_s1[1]) + NUM_W'(den_t_s1[2]);
			num_s2 <= NUM_W'(num_t_s1[0]) + NUM_W'(num_t_s1[1]) + NUM_W'(num_t_s1[2]);

			// drop parallel rays, rays on/behind the plane, and t beyond 31 bits
			ray_s3  <= ray_s2;
			nd_s3   <= nd_c;
			rem_s3  <= nn_c >> IB_W;
			nlow_s3 <= nn_c[IB_W-1:0];
			miss_s3 <= (den_s2 == '0) || (nd_c < MAG_W'(PARALLEL_LIMIT_LSB))
				|| (num_s2 == '0) || (num_s2[NUM_W-1] != den_s2[NUM_W-1])
				|| ((nn_c >> IB_W) >= nd_c);

			ray_s4  <= dv_ray[DIV_N];
			t_s4    <= t_c;
			cand_s4 <= tok_c;
			for (int i = 0; i < 3; i++) begin
				pp_s4[i] <= pp[i][63:FRAC_BITS];
			end

			t_s5    <= t_s4;
			near_s5 <= ray_s4.near;
			cand_s5 <= cand_s4 && !far_c;
			for (int i = 0; i < 3; i++) begin
				pt_s5[i] <= sat32(pt_c[i]);
				mg_s5[i] <= mg_c[i][VAL_W-1:0];
			end

			t_s6    <= t_s5;
			near_s6 <= near_s5;
			cand_s6 <= cand_s5;
			for (int i = 0; i < 3; i++) begin
				pt_s6[i] <= pt_s5[i];
				sq_s6[i] <= sqf[i][63:FRAC_BITS];
			end

			out_s7 <= out_c;
		end
	end

	assign m_axis_tvalid = v_s7;
	assign m_axis_tdata  = out_s7;

endmodule
`default_nettype wire

### hw/rtl/rdc_checker.sv
// Port-level checks for the ray/disk cap intersector, bound to the top level.
// Depends on rdc_pkg and the assertion macros header.
`default_nettype none
`include "ray_disk_cap_intersect_macros.svh"
module rdc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [rdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [rdc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [rdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [rdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import rdc_pkg::*;

	logic            hit;
	logic [T_W-1:0]  hit_t;
	logic [T_W-1:0]  new_near;
	assign hit      = m_axis_tvalid && m_axis_tdata[O_HIT];
	assign hit_t    = m_axis_tdata[O_T +: T_W];
	assign new_near = m_axis_tdata[O_NEAR +: T_W];

	`RDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`RDC_ASSERT_IMPL(a_miss_zero, m_axis_tvalid && !m_axis_tdata[O_HIT], m_axis_tdata[O_NEAR-1:O_T] == '0, "miss carries nonzero fields")
	`RDC_ASSERT_IMPL(a_hit_near, hit, hit_t == new_near, "hit distance not forwarded as nearest")
	`RDC_ASSERT_IMPL(a_hit_tmin, hit, hit_t > T_W'(MIN_T_LSB), "hit at or below minimum distance")
	`RDC_ASSERT_IMPL(a_ready_free, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

	logic unused_ok;
	assign unused_ok = cfg_we ^ (^cfg_index) ^ (^cfg_data) ^ s_axis_tvalid ^ (^s_axis_tdata);

endmodule

bind ray_disk_cap_intersect rdc_checker u_rdc_checker (.*);
`default_nettype wire

### dv/tb_ray_disk_cap_intersect.sv
// Self-checking testbench for the ray versus circular cap intersector.
// Depends on rdc_pkg (register codes, widths) and ray_disk_cap_intersect.
`timescale 1ns / 1ps
`default_nettype none
module tb_ray_disk_cap_intersect;
	import rdc_pkg::*;

	localparam int RAYS_PER_PHASE = 115;
	localparam int NUM_PHASES     = 6;
	localparam int LATENCY        = 38;
	localparam int CYCLE_LIMIT    = 600000;
	localparam logic [31:0] ONE   = 32'h0001_0000;

	// One ray as carried by the input stream.
	typedef struct packed {
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
		logic [30:0]      nearest;
	} ray_t;

	// One cap test outcome as carried by the output stream.
	typedef struct packed {
		logic             hit;
		logic [30:0]      t;
		logic [2:0][31:0] pt;
		logic [2:0][31:0] nrm;
		logic [30:0]      nearest;
	} cap_hit_t;

	typedef struct {
		ray_t     ray;
		logic     typed;
		cap_hit_t want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_t, pad
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// hit_found, hit_t, point_x/y/z, normal_x/y/z, new_nearest_t, pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	ray_disk_cap_intersect dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the cap registers, updated on every write.
	logic [2:0][31:0] cap_ctr;
	logic [2:0][31:0] cap_axis;
	logic [30:0]      cap_rsq;
	logic             cap_top;

	cap_hit_t cap_results_due[$];
	stim_row_t directed_rows[$];
	int  failures;
	int  rays_sent;
	int  results_seen;
	int  hits_seen;
	int  cycle_count;
	bit  calm;   // no idling on either side in the closing phase

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint unsigned magnitude(input longint a);
		return (a < 0) ? longint'(-a) : longint'(a);
	endfunction

	// floor(a*b / 2^F), with the exact product held in 64 bits
	function automatic longint fixed_mul(input longint a, input longint b);
		longint unsigned m;
		m = magnitude(a) * magnitude(b);
		if ((a < 0) == (b < 0)) begin
			return longint'(m >> FRAC_BITS);
		end
		return -longint'((m + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sh7FFF_FFFF) begin
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic cap_hit_t cap_hit_predict(input ray_t ray);
		cap_hit_t res;
		longint org[3];
		longint dir[3];
		longint ctr[3];
		longint ax[3];
		longint pt[3];
		longint den;
		longint num;
		longint unsigned nd;
		longint unsigned nn;
		longint unsigned q;
		longint unsigned r;
		longint unsigned t;
		longint unsigned m;
		longint unsigned dist_sum;
		res = '0;
		res.nearest = ray.nearest;
		den = 0;
		num = 0;
		dist_sum = 0;
		for (int i = 0; i < 3; i++) begin
			org[i] = longint'($signed(ray.org[i]));
			dir[i] = longint'($signed(ray.dir[i]));
			ctr[i] = longint'($signed(cap_ctr[i]));
			ax[i]  = longint'($signed(cap_axis[i]));
			den += fixed_mul(dir[i], ax[i]);
			num += fixed_mul(ctr[i] - org[i], ax[i]);
		end
		nd = magnitude(den);
		nn = magnitude(num);
		// parallel ray, or plane behind / at the origin
		if (den == 0 || nd < PARALLEL_LIMIT_LSB) begin
			return res;
		end
		if (num == 0 || ((num < 0) != (den < 0))) begin
			return res;
		end
		q = nn / nd;
		r = nn % nd;
		if (q > (64'h7FFF_FFFF >> FRAC_BITS)) begin
			return res;
		end
		t = q;
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r << 1;
			t = t << 1;
			if (r >= nd) begin
				r -= nd;
				t |= 64'd1;
			end
		end
		if (!(t > MIN_T_LSB && t < longint'(ray.nearest))) begin
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			pt[i] = org[i] + fixed_mul(dir[i], longint'(t));
			m = magnitude(pt[i] - ctr[i]);
			if (m >= (64'd1 << 32)) begin
				return res;
			end
			dist_sum += (m * m) >> FRAC_BITS;
		end
		if (dist_sum > longint'(cap_rsq)) begin
			return res;
		end
		res.hit = 1'b1;
		res.t = t[30:0];
		res.nearest = t[30:0];
		for (int i = 0; i < 3; i++) begin
			res.pt[i]  = clamp32(pt[i]);
			res.nrm[i] = clamp32(cap_top ? ax[i] : -ax[i]);
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Configuration: one write per cycle; the caller drops cfg_we
	// ------------------------------------------------------------------
	task automatic write_cap_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx) inside
			REG_CTR_X, REG_CTR_Y, REG_CTR_Z: begin
				cap_ctr[int'(idx) - int'(REG_CTR_X)] = val;
			end
			REG_AXIS_X, REG_AXIS_Y, REG_AXIS_Z: begin
				cap_axis[int'(idx) - int'(REG_AXIS_X)] = val;
			end
			REG_RSQ: begin
				cap_rsq = val[30:0];
			end
			default: begin
				cap_top = val[0];
			end
		endcase
		@(posedge clk);
	endtask

	task automatic program_cap(input logic [2:0][31:0] ctr, input logic [2:0][31:0] ax,
			input logic [30:0] rsq, input logic top);
		write_cap_reg(REG_CTR_X, ctr[0]);
		write_cap_reg(REG_CTR_Y, ctr[1]);
		write_cap_reg(REG_CTR_Z, ctr[2]);
		write_cap_reg(REG_AXIS_X, ax[0]);
		write_cap_reg(REG_AXIS_Y, ax[1]);
		write_cap_reg(REG_AXIS_Z, ax[2]);
		write_cap_reg(REG_RSQ, {1'b0, rsq});
		write_cap_reg(REG_NSIGN, {31'd0, top});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Hold until every result is back, then let the pipe drain fully.
	task automatic wait_drained();
		while (cap_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Present one ray and hold it until the transaction completes. Valid is
	// left high unless the task adds a random gap; the caller drops it after its last ray.
	task automatic send_ray(input ray_t ray, input logic typed, input cap_hit_t want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, ray.nearest, ray.dir[2], ray.dir[1], ray.dir[0],
			ray.org[2], ray.org[1], ray.org[0]};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		cap_results_due.push_back(typed ? want : cap_hit_predict(ray));
		rays_sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] jitter(input int span);
		return 32'($signed($urandom_range(0, 2 * span))) - 32'(span);
	endfunction

	// Mostly rays launched near the cap and pointed at random; the rest noise.
	function automatic ray_t random_ray();
		ray_t ray;
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 3; i++) begin
				ray.org[i] = $urandom;
				ray.dir[i] = $urandom;
			end
			ray.nearest = $urandom;
			return ray;
		end
		for (int i = 0; i < 3; i++) begin
			ray.org[i] = cap_ctr[i] + jitter(1 << 19);
			ray.dir[i] = jitter(1 << 17);
		end
		ray.nearest = ($urandom_range(0, 1) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 22));
		return ray;
	endfunction

	task automatic random_cap();
		logic [2:0][31:0] ctr;
		logic [2:0][31:0] ax;
		int k;
		k = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			ctr[i] = ($urandom_range(0, 3) == 0) ? $urandom : jitter(1 << 20);
			ax[i]  = 32'd0;
		end
		if ($urandom_range(0, 2) == 0) begin
			for (int i = 0; i < 3; i++) begin
				ax[i] = jitter(1 << 16);
			end
		end else begin
			ax[k] = ($urandom_range(0, 1) == 0) ? ONE : -ONE;
		end
		program_cap(ctr, ax, 31'($urandom_range(0, 1 << 24)), 1'($urandom));
	endtask

	function automatic ray_t mk_ray(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] oz, input logic [31:0] dx, input logic [31:0] dy,
			input logic [31:0] dz, input logic [30:0] near);
		ray_t ray;
		ray.org = {oz, oy, ox};
		ray.dir = {dz, dy, dx};
		ray.nearest = near;
		return ray;
	endfunction

	task automatic add_row(input ray_t ray, input logic typed, input cap_hit_t want);
		stim_row_t row;
		row.ray = ray;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// A miss keeps every result field at zero and passes nearest through.
	task automatic add_miss(input ray_t ray);
		cap_hit_t want;
		want = '0;
		want.nearest = ray.nearest;
		add_row(ray, 1'b1, want);
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall bursts, none in the closing phase
	// ------------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare every result transaction against the oldest prediction.
	always @(posedge clk) begin
		cap_hit_t got;
		cap_hit_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tdata[O_HIT];
			got.t = m_axis_tdata[O_T +: T_W];
			for (int i = 0; i < 3; i++) begin
				got.pt[i]  = m_axis_tdata[O_PT + 32 * i +: 32];
				got.nrm[i] = m_axis_tdata[O_NRM + 32 * i +: 32];
			end
			got.nearest = m_axis_tdata[O_NEAR +: T_W];
			results_seen++;
			if (got.hit) begin
				hits_seen++;
			end
			if (cap_results_due.size() == 0) begin
				$error("result with no ray outstanding: %h", m_axis_tdata);
				failures++;
			end else begin
				want = cap_results_due.pop_front();
				if (got.hit !== want.hit) begin
					$error("hit_found: expected %0d, got %0d", want.hit, got.hit);
					failures++;
				end
				if (got.t !== want.t) begin
					$error("hit_t: expected %h, got %h", want.t, got.t);
					failures++;
				end
				for (int i = 0; i < 3; i++) begin
					if (got.pt[i] !== want.pt[i]) begin
						$error("point[%0d]: expected %h, got %h", i, want.pt[i], got.pt[i]);
						failures++;
					end
					if (got.nrm[i] !== want.nrm[i]) begin
						$error("normal[%0d]: expected %h, got %h", i, want.nrm[i], got.nrm[i]);
						failures++;
					end
				end
				if (got.nearest !== want.nearest) begin
					$error("new_nearest_t: expected %h, got %h", want.nearest, got.nearest);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ray_disk_cap_intersect verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		cap_hit_t want;
		logic [2:0][31:0] ctr;
		logic [2:0][31:0] ax;
		failures = 0;
		rays_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		cycle_count = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CTR_X;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		// reset register values: center 0, axis +y, radius^2 1.0, bottom cap
		cap_ctr = '0;
		cap_axis = '0;
		cap_axis[1] = ONE;
		cap_rsq = 31'(ONE);
		cap_top = 1'b0;

		// Straight down onto the bottom cap from y=5: t=5, point at the center.
		want = '0;
		want.hit = 1'b1;
		want.t = 31'(5 * ONE);
		want.nrm[1] = -ONE;
		want.nearest = 31'(5 * ONE);
		add_row(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 31'h7FFF_FFFF), 1'b1, want);
		// parallel to the plane, all-zero ray
		add_miss(mk_ray(0, 5 * ONE, 0, ONE, 0, 0, 31'h7FFF_FFFF));
		add_miss(mk_ray(0, 0, 0, 0, 0, 0, 0));
		// plane behind the origin, origin on the plane
		add_miss(mk_ray(0, 5 * ONE, 0, 0, ONE, 0, 31'h7FFF_FFFF));
		add_miss(mk_ray(0, 0, 0, 0, -ONE, 0, 31'h7FFF_FFFF));
		// t not below nearest, nearest zero
		add_miss(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 31'(5 * ONE)));
		add_miss(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 0));
		// t at the minimum
		add_miss(mk_ray(0, 1, 0, 0, -ONE, 0, 31'h7FFF_FFFF));
		// landing outside the radius
		add_miss(mk_ray(2 * ONE, 5 * ONE, 0, 0, -ONE, 0, 31'h7FFF_FFFF));
		// t beyond the 31-bit range
		add_miss(mk_ray(0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 31'h7FFF_FFFF));
		// far point, at the positive x limit
		add_miss(mk_ray(32'h7FFF_FFFF, 5 * ONE, 0, 0, -ONE, 0, 31'h7FFF_FFFF));
		// the rest go through the predictor
		add_row(mk_ray(ONE, 5 * ONE, 0, 0, -ONE, 0, 31'h7FFF_FFFF), 1'b0, want);
		add_row(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF), 1'b0, want);
		add_row(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF), 1'b0, want);
		add_row(mk_ray(ONE / 4, 3 * ONE, -(ONE / 4), ONE / 10, -ONE, ONE / 10,
			31'h7FFF_FFFF), 1'b0, want);
		add_row(mk_ray(-(ONE / 2), -3 * ONE, ONE / 3, 0, ONE / 2, -(ONE / 8),
			31'(100 * ONE)), 1'b0, want);
		add_row(mk_ray(0, ONE / 2, 0, ONE / 4, -(ONE / 4), 0, 31'(ONE / 2)), 1'b0, want);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rays against the reset configuration
		foreach (directed_rows[i]) begin
			send_ray(directed_rows[i].ray, directed_rows[i].typed, directed_rows[i].want);
		end
		s_axis_tvalid <= 1'b0;

		for (int ph = 1; ph <= NUM_PHASES; ph++) begin
			wait_drained();
			if (ph == 1) begin
				// extremes: max center, most negative axis (normal saturates), bottom cap
				ctr = {3{32'h7FFF_FFFF}};
				ax  = {3{32'h8000_0000}};
				program_cap(ctr, ax, 31'h7FFF_FFFF, 1'b0);
			end else if (ph == 2) begin
				// opposite extremes, top cap
				ctr = {3{32'h8000_0000}};
				ax  = {3{32'h7FFF_FFFF}};
				program_cap(ctr, ax, 31'd0, 1'b1);
			end else begin
				random_cap();
			end
			calm = (ph == NUM_PHASES);
			want = '0;
			for (int n = 0; n < RAYS_PER_PHASE; n++) begin
				send_ray(random_ray(), 1'b0, want);
			end
			s_axis_tvalid <= 1'b0;
		end

		wait_drained();
		$display("%0d rays over %0d cap settings plus directed cases; %0d results, %0d hits",
			rays_sent, NUM_PHASES + 1, results_seen, hits_seen);
		if (failures == 0) begin
			$display("ray_disk_cap_intersect verification clean");
		end else begin
			$display("ray_disk_cap_intersect verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

### ray_disk_cap_intersect.f
+incdir+hw/rtl
hw/rtl/rdc_pkg.sv
hw/rtl/ray_disk_cap_intersect.sv
hw/rtl/rdc_checker.sv
dv/tb_ray_disk_cap_intersect.sv
